>>> rtl/rbfc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rbfc_pkg;

    // Field widths of the channels
    localparam int OP_W       = 2;
    localparam int CNT_W      = 31;
    localparam int OFS_W      = 30;
    localparam int BSZ_W      = 31;
    localparam int FSM_W      = 23;
    localparam int STAT32_W   = 32;
    localparam int STAT48_W   = 48;
    localparam int IDX_W      = 2;
    localparam int CFG_DATA_W = 31;

    // Opcodes
    localparam logic [OP_W-1:0] OP_ARRIVE  = 2'd0;
    localparam logic [OP_W-1:0] OP_CONSUME = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR   = 2'd2;
    localparam logic [OP_W-1:0] OP_NOP     = 2'd3;

    // Register indexes
    localparam logic [IDX_W-1:0] REG_BUFFER_SIZE    = 2'd0;
    localparam logic [IDX_W-1:0] REG_FREE_SPACE_MIN = 2'd1;
    localparam logic [IDX_W-1:0] REG_BUSY_ENABLE    = 2'd2;

    // Register reset values
    localparam logic [BSZ_W-1:0] BUFFER_SIZE_RST    = 31'd1073741824;
    localparam logic [FSM_W-1:0] FREE_SPACE_MIN_RST = 23'd4194304;

    // Step strobes from the controller to the datapath
    typedef struct packed {
        logic load;
        logic calc;
        logic check;
        logic commit;
        logic report;
    } rbfc_cmd_t;

    // One result word
    typedef struct packed {
        logic                accepted;
        logic [OFS_W-1:0]    write_offset;
        logic [OFS_W-1:0]    read_offset;
        logic [CNT_W-1:0]    bytes_available;
        logic                full_res;
        logic                full_occurred;
        logic                busy_res;
        logic [STAT32_W-1:0] packets_received;
        logic [STAT32_W-1:0] packets_lost;
        logic [STAT48_W-1:0] bytes_received;
        logic [STAT48_W-1:0] bytes_lost;
        logic [STAT32_W-1:0] buffer_wraps;
    } rbfc_res_t;

endpackage

`default_nettype wire

>>> rtl/rbfc_if.sv
`timescale 1ns / 1ps
`default_nettype none

// Event channel: opcode and byte count
interface rbfc_evt_if import rbfc_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [OP_W-1:0]  opcode;
    logic [CNT_W-1:0] byte_count;

    modport source (output valid, opcode, byte_count, input ready);
    modport sink   (input valid, opcode, byte_count, output ready);
endinterface

// Result channel: one word per event
interface rbfc_res_if import rbfc_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                accepted;
    logic [OFS_W-1:0]    write_offset;
    logic [OFS_W-1:0]    read_offset;
    logic [CNT_W-1:0]    bytes_available;
    logic                full_res;
    logic                full_occurred;
    logic                busy_res;
    logic [STAT32_W-1:0] packets_received;
    logic [STAT32_W-1:0] packets_lost;
    logic [STAT48_W-1:0] bytes_received;
    logic [STAT48_W-1:0] bytes_lost;
    logic [STAT32_W-1:0] buffer_wraps;

    modport source (output valid, accepted, write_offset, read_offset, bytes_available,
                    full_res, full_occurred, busy_res, packets_received, packets_lost,
                    bytes_received, bytes_lost, buffer_wraps, input ready);
    modport sink   (input valid, accepted, write_offset, read_offset, bytes_available,
                    full_res, full_occurred, busy_res, packets_received, packets_lost,
                    bytes_received, bytes_lost, buffer_wraps, output ready);
endinterface

// Configuration write channel
interface rbfc_cfg_if import rbfc_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [IDX_W-1:0]      index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> rtl/rbfc_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module rbfc_ctrl import rbfc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      evt_valid,
    output logic      evt_ready,
    output logic      res_valid,
    input  logic      res_ready,
    output rbfc_cmd_t cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_CALC   = 3'd1;
    localparam logic [2:0] ST_CHECK  = 3'd2;
    localparam logic [2:0] ST_COMMIT = 3'd3;
    localparam logic [2:0] ST_REPORT = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       res_valid_reg;
    logic       res_valid_next;
    logic       out_free;

    // Output register can take a word when empty or being drained
    assign out_free  = !res_valid_reg || res_ready;
    assign evt_ready = (state_reg == ST_IDLE);
    assign res_valid = res_valid_reg;

    // Sequence one event through the datapath steps
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (evt_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CALC;
                end
            end
            ST_CALC:
            begin
                cmd.calc   = 1'b1;
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                cmd.check  = 1'b1;
                state_next = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                cmd.commit = 1'b1;
                state_next = ST_REPORT;
            end
            ST_REPORT:
            begin
                if (out_free)
                begin
                    cmd.report = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold the result word until the receiver takes it
    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (cmd.report)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    a_accept_starts_calc: assert property (@(posedge clk) disable iff (!rst_n)
        (evt_valid && evt_ready) |=> (state_reg == ST_CALC))
        else $error("accepted event did not start the calculation step");

    a_valid_from_report: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(state_reg == ST_REPORT))
        else $error("result word appeared outside the report step");

    a_one_step: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(cmd))
        else $error("more than one datapath step strobed");

endmodule

`default_nettype wire

>>> rtl/rbfc_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module rbfc_datapath import rbfc_pkg::*;
#(
    parameter int POINTER_BITS = 30,
    parameter int MAX_PACKET   = 16384
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  rbfc_cmd_t             cmd,
    input  logic [OP_W-1:0]       opcode,
    input  logic [CNT_W-1:0]      byte_count,
    input  logic                  cfg_write,
    input  logic [IDX_W-1:0]      cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output rbfc_res_t             res
);

    localparam int PB    = POINTER_BITS;
    localparam int LEN_W = $clog2(MAX_PACKET + 1);
    localparam int END_W = PB + 1;
    localparam int WIDE  = (PB + 2 > 32) ? PB + 2 : 32;
    localparam logic [LEN_W-1:0] MAX_LEN   = LEN_W'(MAX_PACKET);
    localparam logic [WIDE-1:0]  RING_LIM  = WIDE'(1) << PB;
    localparam logic [WIDE-1:0]  MAX_WIDE  = WIDE'(MAX_PACKET);

    // Configuration registers
    logic [BSZ_W-1:0] bsize_reg;
    logic [FSM_W-1:0] fsm_reg;
    logic             busy_en_reg;

    // Event latch and working registers
    logic [OP_W-1:0]  op_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [LEN_W-1:0] len_reg;
    logic [END_W-1:0] nh_reg;
    logic [WIDE-1:0]  tsum_reg;
    logic [CNT_W:0]   fsum_reg;
    logic [WIDE-1:0]  ring_reg;
    logic [PB-1:0]    wroff_reg;
    logic             wrap_reg;
    logic             hit_wrap_reg;
    logic             hit_keep_reg;
    logic [FSM_W-1:0] gap_wrap_reg;
    logic [FSM_W-1:0] gap_keep_reg;
    logic             tzero_reg;
    logic             acc_reg;
    logic             acc_next;
    rbfc_res_t        res_reg;

    // Ring state
    logic [PB-1:0]       head_reg,       head_next;
    logic [PB-1:0]       tail_reg,       tail_next;
    logic [END_W-1:0]    wrap_end_reg,   wrap_end_next;
    logic [CNT_W-1:0]    free_reg,       free_next;
    logic                full_reg,       full_next;
    logic                seen_reg,       seen_next;
    logic                busy_reg,       busy_next;
    logic [STAT32_W-1:0] pkts_rx_reg,    pkts_rx_next;
    logic [STAT32_W-1:0] pkts_lost_reg,  pkts_lost_next;
    logic [STAT48_W-1:0] bytes_rx_reg,   bytes_rx_next;
    logic [STAT48_W-1:0] bytes_lost_reg, bytes_lost_next;
    logic [STAT32_W-1:0] wraps_reg,      wraps_next;

    // Step combinational values
    logic [LEN_W-1:0]    len_calc;
    logic [WIDE-1:0]     gap_keep_full;
    logic [CNT_W-1:0]    fsat;
    logic                hit;
    logic [FSM_W-1:0]    gap;
    logic [STAT48_W:0]   bytes_sum;
    logic [CNT_W-1:0]    avail;

    // Take configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bsize_reg   <= BUFFER_SIZE_RST;
            fsm_reg     <= FREE_SPACE_MIN_RST;
            busy_en_reg <= 1'b1;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_BUFFER_SIZE:    bsize_reg   <= cfg_data[BSZ_W-1:0];
                REG_FREE_SPACE_MIN: fsm_reg     <= cfg_data[FSM_W-1:0];
                REG_BUSY_ENABLE:    busy_en_reg <= cfg_data[0];
                default:            ;
            endcase
        end
    end

    // Clamp the packet length
    assign len_calc = (cnt_reg > CNT_W'(MAX_PACKET)) ? MAX_LEN : LEN_W'(cnt_reg);

    // Gap from the unwrapped head up to the tail
    assign gap_keep_full = WIDE'(tail_reg) - WIDE'(nh_reg);

    // Latch the event, then compute sums and compares a step at a time
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= opcode;
            cnt_reg <= byte_count;
        end
        if (cmd.calc)
        begin
            len_reg   <= len_calc;
            nh_reg    <= END_W'(head_reg) + END_W'(len_calc);
            tsum_reg  <= WIDE'(tail_reg) + WIDE'(cnt_reg);
            fsum_reg  <= {1'b0, free_reg} + {1'b0, cnt_reg};
            ring_reg  <= (WIDE'(bsize_reg) < RING_LIM) ? WIDE'(bsize_reg) : RING_LIM;
            wroff_reg <= (op_reg == OP_CLEAR) ? '0 : head_reg;
        end
        if (cmd.check)
        begin
            wrap_reg     <= (WIDE'(nh_reg) + MAX_WIDE) > ring_reg;
            hit_keep_reg <= (WIDE'(tail_reg) >= WIDE'(nh_reg))
                            && (gap_keep_full < WIDE'(fsm_reg));
            gap_keep_reg <= FSM_W'(gap_keep_full);
            hit_wrap_reg <= WIDE'(tail_reg) < WIDE'(fsm_reg);
            gap_wrap_reg <= FSM_W'(tail_reg);
            tzero_reg    <= (tsum_reg == WIDE'(wrap_end_reg));
        end
        if (cmd.commit)
        begin
            acc_reg <= acc_next;
        end
        if (cmd.report)
        begin
            res_reg <= '{
                accepted:         acc_reg,
                write_offset:     OFS_W'(wroff_reg),
                read_offset:      OFS_W'(tail_reg),
                bytes_available:  avail,
                full_res:         full_reg,
                full_occurred:    seen_reg,
                busy_res:         busy_reg && busy_en_reg,
                packets_received: pkts_rx_reg,
                packets_lost:     pkts_lost_reg,
                bytes_received:   bytes_rx_reg,
                bytes_lost:       bytes_lost_reg,
                buffer_wraps:     wraps_reg
            };
        end
    end

    // Saturate the freed-space sum and pick the watermark gap
    assign fsat = fsum_reg[CNT_W] ? '1 : fsum_reg[CNT_W-1:0];
    assign hit  = wrap_reg ? hit_wrap_reg : hit_keep_reg;
    assign gap  = wrap_reg ? gap_wrap_reg : gap_keep_reg;

    // Update the ring state at commit
    always_comb
    begin
        head_next       = head_reg;
        tail_next       = tail_reg;
        wrap_end_next   = wrap_end_reg;
        free_next       = free_reg;
        full_next       = full_reg;
        seen_next       = seen_reg;
        busy_next       = busy_reg;
        pkts_rx_next    = pkts_rx_reg;
        pkts_lost_next  = pkts_lost_reg;
        bytes_rx_next   = bytes_rx_reg;
        bytes_lost_next = bytes_lost_reg;
        wraps_next      = wraps_reg;
        acc_next        = 1'b0;
        bytes_sum       = '0;
        if (cmd.commit)
        begin
            case (op_reg)
                OP_ARRIVE:
                begin
                    if (cnt_reg != '0)
                    begin
                        if (full_reg)
                        begin
                            // Drop the packet
                            if (!(&pkts_lost_reg))
                            begin
                                pkts_lost_next = pkts_lost_reg + 1'b1;
                            end
                            bytes_sum       = {1'b0, bytes_lost_reg}
                                              + (STAT48_W + 1)'(len_reg);
                            bytes_lost_next = bytes_sum[STAT48_W] ? '1
                                              : bytes_sum[STAT48_W-1:0];
                        end
                        else
                        begin
                            // Store the packet and advance the head
                            acc_next = 1'b1;
                            if (wrap_reg)
                            begin
                                wrap_end_next = nh_reg;
                                head_next     = '0;
                                if (!(&wraps_reg))
                                begin
                                    wraps_next = wraps_reg + 1'b1;
                                end
                            end
                            else
                            begin
                                head_next = nh_reg[PB-1:0];
                            end
                            if (hit)
                            begin
                                if (busy_en_reg)
                                begin
                                    free_next = CNT_W'(gap);
                                    busy_next = 1'b1;
                                end
                                full_next = 1'b1;
                                seen_next = 1'b1;
                            end
                            if (!(&pkts_rx_reg))
                            begin
                                pkts_rx_next = pkts_rx_reg + 1'b1;
                            end
                            bytes_sum     = {1'b0, bytes_rx_reg}
                                            + (STAT48_W + 1)'(len_reg);
                            bytes_rx_next = bytes_sum[STAT48_W] ? '1
                                            : bytes_sum[STAT48_W-1:0];
                        end
                    end
                end
                OP_CONSUME:
                begin
                    // Advance the tail and release busy past the watermark
                    tail_next = tzero_reg ? '0 : tsum_reg[PB-1:0];
                    if (busy_reg && busy_en_reg)
                    begin
                        free_next = fsat;
                        if (fsat > CNT_W'(fsm_reg))
                        begin
                            busy_next = 1'b0;
                        end
                    end
                    full_next = 1'b0;
                end
                OP_CLEAR:
                begin
                    head_next       = '0;
                    tail_next       = '0;
                    full_next       = 1'b0;
                    seen_next       = 1'b0;
                    busy_next       = 1'b0;
                    free_next       = bsize_reg;
                    pkts_rx_next    = '0;
                    pkts_lost_next  = '0;
                    bytes_rx_next   = '0;
                    bytes_lost_next = '0;
                end
                OP_NOP:
                begin
                    acc_next = 1'b0;
                end
                default:
                begin
                    acc_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg       <= '0;
            tail_reg       <= '0;
            wrap_end_reg   <= '0;
            free_reg       <= BUFFER_SIZE_RST;
            full_reg       <= 1'b0;
            seen_reg       <= 1'b0;
            busy_reg       <= 1'b0;
            pkts_rx_reg    <= '0;
            pkts_lost_reg  <= '0;
            bytes_rx_reg   <= '0;
            bytes_lost_reg <= '0;
            wraps_reg      <= '0;
        end
        else
        begin
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            wrap_end_reg   <= wrap_end_next;
            free_reg       <= free_next;
            full_reg       <= full_next;
            seen_reg       <= seen_next;
            busy_reg       <= busy_next;
            pkts_rx_reg    <= pkts_rx_next;
            pkts_lost_reg  <= pkts_lost_next;
            bytes_rx_reg   <= bytes_rx_next;
            bytes_lost_reg <= bytes_lost_next;
            wraps_reg      <= wraps_next;
        end
    end

    // Contiguous readable span from the tail
    always_comb
    begin
        if (tail_reg < head_reg)
        begin
            avail = CNT_W'(head_reg - tail_reg);
        end
        else if ((head_reg == tail_reg) && !full_reg)
        begin
            avail = '0;
        end
        else if (wrap_end_reg > END_W'(tail_reg))
        begin
            avail = CNT_W'(wrap_end_reg - END_W'(tail_reg));
        end
        else
        begin
            avail = '0;
        end
    end

    assign res = res_reg;

    a_busy_implies_seen: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> seen_reg)
        else $error("busy set without the sticky full flag");

    a_full_implies_seen: assert property (@(posedge clk) disable iff (!rst_n)
        full_reg |-> seen_reg)
        else $error("full set without the sticky full flag");

    a_commit_after_check: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> $past(cmd.check))
        else $error("commit without a preceding check step");

endmodule

`default_nettype wire

>>> rtl/ring_buffer_flow_control.sv
// Ring buffer flow control: tracks head, tail and end mark of a byte ring
// that receives variable-length packets, with a watermark that raises full
// and busy, and saturating packet and byte statistics. No payload is held.
//
// Channels: evt carries one event word (opcode, byte_count): arrival,
// consume, clear or no operation. res returns exactly one result word per
// event. cfg writes buffer_size, free_space_min and busy_enable by index;
// it is always ready and must be written only while no event is in flight,
// a rule the user keeps; the block itself does not enforce it.
// Once an event is accepted, the controller runs a four-step sequence
// (sum, compare, commit, report) and registers the result word at the
// report step. evt is ready only while the controller is idle, so a new
// event is taken only after the last one has been reported.
//
// Stall: a result word waits in the output register; the next event is
// still accepted, and its result is held in the report step until the
// register drains.
// Reset: pointers, flags and counters clear, free count and registers take
// their reset values; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module ring_buffer_flow_control import rbfc_pkg::*;
#(
    parameter int POINTER_BITS = 30,
    parameter int MAX_PACKET   = 16384
)
(
    input  logic      clk,
    input  logic      rst_n,
    rbfc_evt_if.sink  evt,
    rbfc_res_if.source res,
    rbfc_cfg_if.sink  cfg
);

    rbfc_cmd_t cmd;
    rbfc_res_t res_word;
    logic      evt_ready;
    logic      res_valid;

    // Sequence each event
    rbfc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .evt_valid (evt.valid),
        .evt_ready (evt_ready),
        .res_valid (res_valid),
        .res_ready (res.ready),
        .cmd       (cmd)
    );

    // Ring state, statistics and configuration
    rbfc_datapath #(
        .POINTER_BITS (POINTER_BITS),
        .MAX_PACKET   (MAX_PACKET)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .opcode     (evt.opcode),
        .byte_count (evt.byte_count),
        .cfg_write  (cfg.valid),
        .cfg_index  (cfg.index),
        .cfg_data   (cfg.data),
        .res        (res_word)
    );

    assign evt.ready = evt_ready;
    assign cfg.ready = 1'b1;

    // Drive the result channel
    assign res.valid            = res_valid;
    assign res.accepted         = res_word.accepted;
    assign res.write_offset     = res_word.write_offset;
    assign res.read_offset      = res_word.read_offset;
    assign res.bytes_available  = res_word.bytes_available;
    assign res.full_res         = res_word.full_res;
    assign res.full_occurred    = res_word.full_occurred;
    assign res.busy_res         = res_word.busy_res;
    assign res.packets_received = res_word.packets_received;
    assign res.packets_lost     = res_word.packets_lost;
    assign res.bytes_received   = res_word.bytes_received;
    assign res.bytes_lost       = res_word.bytes_lost;
    assign res.buffer_wraps     = res_word.buffer_wraps;

endmodule

`default_nettype wire

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;
    import rbfc_pkg::*;

    localparam int        PTR_BITS = 30;
    localparam int        MAX_PKT  = 16384;
    localparam bit [63:0] MAX31    = 64'h7FFF_FFFF;
    localparam bit [63:0] MAX32    = 64'hFFFF_FFFF;
    localparam bit [63:0] MAX48    = 64'hFFFF_FFFF_FFFF;

    // Ring bookkeeping mirror: tracks pointers, flags and counters and
    // queues the result word each accepted event should produce.
    class ring_ledger;
        bit [BSZ_W-1:0]    buffer_size;
        bit [FSM_W-1:0]    free_space_min;
        bit                busy_enable;
        bit [OFS_W-1:0]    head;
        bit [OFS_W-1:0]    tail;
        bit [CNT_W-1:0]    wrap_end;
        bit [CNT_W-1:0]    free_count;
        bit                full;
        bit                full_seen;
        bit                busy;
        bit [STAT32_W-1:0] pkts_in;
        bit [STAT32_W-1:0] pkts_lost;
        bit [STAT32_W-1:0] wraps;
        bit [STAT48_W-1:0] bytes_in;
        bit [STAT48_W-1:0] bytes_lost;
        rbfc_res_t         expected_reports[$];
        int                errors;

        function new();
            buffer_size    = BUFFER_SIZE_RST;
            free_space_min = FREE_SPACE_MIN_RST;
            busy_enable    = 1'b1;
            head           = '0;
            tail           = '0;
            wrap_end       = '0;
            free_count     = BUFFER_SIZE_RST;
            full           = 1'b0;
            full_seen      = 1'b0;
            busy           = 1'b0;
            pkts_in        = '0;
            pkts_lost      = '0;
            wraps          = '0;
            bytes_in       = '0;
            bytes_lost     = '0;
            errors         = 0;
        endfunction

        function bit [63:0] sat_add(bit [63:0] a, bit [63:0] b, bit [63:0] top);
            return (b > top - a) ? top : a + b;
        endfunction

        function void write_reg(logic [IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_BUFFER_SIZE:    buffer_size    = val[BSZ_W-1:0];
                REG_FREE_SPACE_MIN: free_space_min = val[FSM_W-1:0];
                REG_BUSY_ENABLE:    busy_enable    = val[0];
                default: ;
            endcase
        endfunction

        // Contiguous readable span from the tail
        function bit [CNT_W-1:0] avail_now();
            if (tail < head)
                return head - tail;
            if (head == tail && !full)
                return '0;
            return (wrap_end > tail) ? wrap_end - tail : '0;
        endfunction

        function int pending();
            return expected_reports.size();
        endfunction

        // Advance the ring by one accepted event word and queue its report
        function void log_event(logic [OP_W-1:0] op, logic [CNT_W-1:0] cnt);
            bit [63:0] len;
            bit [63:0] nh;
            bit [63:0] t;
            bit [63:0] ring;
            rbfc_res_t exp;
            exp = '0;
            exp.write_offset = head;
            ring = (buffer_size < (64'd1 << PTR_BITS)) ? buffer_size : (64'd1 << PTR_BITS);
            if (op == OP_ARRIVE && cnt != 0) begin
                len = (cnt > MAX_PKT) ? MAX_PKT : cnt;
                if (full) begin
                    pkts_lost  = sat_add(pkts_lost, 1, MAX32);
                    bytes_lost = sat_add(bytes_lost, len, MAX48);
                end
                else begin
                    nh = head + len;
                    exp.accepted = 1'b1;
                    // wrap when a largest-size packet would no longer fit
                    if (nh + MAX_PKT > ring) begin
                        wrap_end = nh;
                        nh       = 0;
                        wraps    = sat_add(wraps, 1, MAX32);
                    end
                    if (tail >= nh && tail - nh < free_space_min) begin
                        if (busy_enable) begin
                            free_count = tail - nh;
                            busy       = 1'b1;
                        end
                        full      = 1'b1;
                        full_seen = 1'b1;
                    end
                    head     = nh;
                    pkts_in  = sat_add(pkts_in, 1, MAX32);
                    bytes_in = sat_add(bytes_in, len, MAX48);
                end
            end
            else if (op == OP_CONSUME) begin
                t = tail + cnt;
                if (t == wrap_end)
                    t = 0;
                if (busy && busy_enable) begin
                    free_count = sat_add(free_count, cnt, MAX31);
                    if (free_count > free_space_min)
                        busy = 1'b0;
                end
                full = 1'b0;
                tail = t;
            end
            else if (op == OP_CLEAR) begin
                head       = '0;
                tail       = '0;
                full       = 1'b0;
                full_seen  = 1'b0;
                busy       = 1'b0;
                free_count = buffer_size;
                pkts_in    = '0;
                pkts_lost  = '0;
                bytes_in   = '0;
                bytes_lost = '0;
                exp.write_offset = '0;
            end
            exp.read_offset      = tail;
            exp.bytes_available  = avail_now();
            exp.full_res         = full;
            exp.full_occurred    = full_seen;
            exp.busy_res         = busy & busy_enable;
            exp.packets_received = pkts_in;
            exp.packets_lost     = pkts_lost;
            exp.bytes_received   = bytes_in;
            exp.bytes_lost       = bytes_lost;
            exp.buffer_wraps     = wraps;
            expected_reports.push_back(exp);
        endfunction

        function void check_field(string name, bit [63:0] want, bit [63:0] got);
            if (want !== got) begin
                $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        // Compare one result word with the oldest queued report
        function void check_report(rbfc_res_t got);
            rbfc_res_t exp;
            if (expected_reports.size() == 0) begin
                $display("%0t: result word with no event pending, expected none, got %h",
                         $time, got);
                errors++;
                return;
            end
            exp = expected_reports.pop_front();
            check_field("accepted",         exp.accepted,         got.accepted);
            check_field("write_offset",     exp.write_offset,     got.write_offset);
            check_field("read_offset",      exp.read_offset,      got.read_offset);
            check_field("bytes_available",  exp.bytes_available,  got.bytes_available);
            check_field("full_res",         exp.full_res,         got.full_res);
            check_field("full_occurred",    exp.full_occurred,    got.full_occurred);
            check_field("busy_res",         exp.busy_res,         got.busy_res);
            check_field("packets_received", exp.packets_received, got.packets_received);
            check_field("packets_lost",     exp.packets_lost,     got.packets_lost);
            check_field("bytes_received",   exp.bytes_received,   got.bytes_received);
            check_field("bytes_lost",       exp.bytes_lost,       got.bytes_lost);
            check_field("buffer_wraps",     exp.buffer_wraps,     got.buffer_wraps);
        endfunction
    endclass

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    bit   hold_request = 1'b0;

    ring_ledger board = new();

    rbfc_evt_if evt_ch ();
    rbfc_res_if res_ch ();
    rbfc_cfg_if cfg_ch ();

    ring_buffer_flow_control #(
        .POINTER_BITS (PTR_BITS),
        .MAX_PACKET   (MAX_PKT)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .evt   (evt_ch),
        .res   (res_ch),
        .cfg   (cfg_ch)
    );

    always #5 clk = ~clk;

    // Offer one event word and hold it until the block takes it
    task automatic send_word(logic [OP_W-1:0] op, logic [CNT_W-1:0] cnt);
        evt_ch.valid      <= 1'b1;
        evt_ch.opcode     <= op;
        evt_ch.byte_count <= cnt;
        @(posedge clk);
        while (!evt_ch.ready)
            @(posedge clk);
        board.log_event(op, cnt);
    endtask

    // Drop valid and wait until every queued report has come back
    task automatic drain();
        evt_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (board.pending() != 0);
    endtask

    // Write all three registers with the block idle
    task automatic load_setting(logic [BSZ_W-1:0] bsz, logic [FSM_W-1:0] fsm, logic ben);
        logic [IDX_W-1:0]      regs [3];
        logic [CFG_DATA_W-1:0] vals [3];
        regs = '{REG_BUFFER_SIZE, REG_FREE_SPACE_MIN, REG_BUSY_ENABLE};
        vals = '{CFG_DATA_W'(bsz), CFG_DATA_W'(fsm), CFG_DATA_W'(ben)};
        drain();
        for (int i = 0; i < 3; i++) begin
            cfg_ch.valid <= 1'b1;
            cfg_ch.index <= regs[i];
            cfg_ch.data  <= vals[i];
            @(posedge clk);
            while (!cfg_ch.ready)
                @(posedge clk);
            board.write_reg(regs[i], vals[i]);
        end
        cfg_ch.valid <= 1'b0;
    endtask

    // Mostly well-formed traffic: arrivals and consumes that follow the
    // readable span, with some oversize, zero, overrun, clear and idle words
    function automatic void pick_event(output logic [OP_W-1:0] op,
                                       output logic [CNT_W-1:0] cnt);
        int unsigned roll;
        int unsigned avl;
        roll = $urandom_range(0, 99);
        avl  = board.avail_now();
        op   = OP_NOP;
        cnt  = $urandom_range(0, 1 << 30);
        if (roll < 45) begin
            op  = OP_ARRIVE;
            cnt = $urandom_range(1, MAX_PKT);
        end
        else if (roll < 80) begin
            op = OP_CONSUME;
            if (avl == 0)
                cnt = $urandom_range(0, 64);
            else if ($urandom_range(0, 1))
                cnt = avl;
            else
                cnt = $urandom_range(1, avl);
        end
        else if (roll < 86) begin
            op = OP_CONSUME;
        end
        else if (roll < 90) begin
            op  = OP_ARRIVE;
            cnt = $urandom_range(0, 1) ? 0 : $urandom_range(MAX_PKT + 1, 1 << 30);
        end
        else if (roll < 93) begin
            op = OP_CLEAR;
        end
        else if (roll >= 96) begin
            op  = OP_ARRIVE;
            cnt = $urandom_range(1, 256);
        end
    endfunction

    // Random words in bursts; optionally start a sink hold-off or a full pause
    task automatic run_phase(int count, bit gaps, int holdoff_at, int pause_at);
        logic [OP_W-1:0]  op;
        logic [CNT_W-1:0] cnt;
        int               burst_left;
        burst_left = $urandom_range(1, 12);
        for (int i = 0; i < count; i++) begin
            pick_event(op, cnt);
            send_word(op, cnt);
            if (i == holdoff_at)
                hold_request = 1'b1;
            if (i == pause_at)
                drain();
            else if (gaps && --burst_left <= 0) begin
                evt_ch.valid <= 1'b0;
                repeat ($urandom_range(1, 6))
                    @(posedge clk);
                burst_left = $urandom_range(1, 12);
            end
        end
    endtask

    // Result sink: check accepted words and stall on a shifting pattern
    initial begin : result_sink
        int        cyc;
        int        mode;
        int        hold_left;
        rbfc_res_t got;
        cyc       = 0;
        mode      = 0;
        hold_left = 0;
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (res_ch.valid && res_ch.ready) begin
                got.accepted         = res_ch.accepted;
                got.write_offset     = res_ch.write_offset;
                got.read_offset      = res_ch.read_offset;
                got.bytes_available  = res_ch.bytes_available;
                got.full_res         = res_ch.full_res;
                got.full_occurred    = res_ch.full_occurred;
                got.busy_res         = res_ch.busy_res;
                got.packets_received = res_ch.packets_received;
                got.packets_lost     = res_ch.packets_lost;
                got.bytes_received   = res_ch.bytes_received;
                got.bytes_lost       = res_ch.bytes_lost;
                got.buffer_wraps     = res_ch.buffer_wraps;
                board.check_report(got);
            end
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = 150;
            end
            if (cyc % 64 == 0)
                mode = $urandom_range(0, 2);
            cyc++;
            // hold off, then always ready, random, or a fixed duty pattern
            if (hold_left > 0) begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end
            else if (mode == 0)
                res_ch.ready <= 1'b1;
            else if (mode == 1)
                res_ch.ready <= $urandom_range(0, 1);
            else
                res_ch.ready <= (cyc % 8) >= 3;
        end
    end

    initial begin : stimulus
        evt_ch.valid      <= 1'b0;
        evt_ch.opcode     <= OP_NOP;
        evt_ch.byte_count <= '0;
        cfg_ch.valid      <= 1'b0;
        cfg_ch.index      <= REG_BUFFER_SIZE;
        cfg_ch.data       <= '0;
        repeat (6)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: idle word, zero, normal and oversize arrivals, consumes, clear
        send_word(OP_NOP, 31'd0);
        send_word(OP_ARRIVE, 31'd0);
        send_word(OP_ARRIVE, 31'd1);
        send_word(OP_ARRIVE, 31'd16384);
        send_word(OP_ARRIVE, 31'd16385);
        send_word(OP_ARRIVE, 31'd1 << 30);
        send_word(OP_CONSUME, 31'd0);
        send_word(OP_CONSUME, 31'd100);
        send_word(OP_CLEAR, 31'd12345);

        // Smallest ring: wrap, full with busy, drop, release, tail overrun
        load_setting(31'd32768, 23'd16384, 1'b1);
        send_word(OP_ARRIVE, 31'd16384);
        send_word(OP_ARRIVE, 31'd100);
        send_word(OP_ARRIVE, 31'd50);
        send_word(OP_CONSUME, 31'd16384);
        send_word(OP_CONSUME, 31'd100);
        send_word(OP_CONSUME, 31'd1 << 30);
        send_word(OP_CONSUME, (31'd1 << 30) - 31'd1);
        send_word(OP_CLEAR, 31'd0);
        send_word(OP_NOP, 31'h7FFF_FFFF);

        // Same ring with busy disabled
        load_setting(31'd32768, 23'd16384, 1'b0);
        send_word(OP_ARRIVE, 31'd16384);
        send_word(OP_ARRIVE, 31'd100);
        send_word(OP_ARRIVE, 31'd50);
        send_word(OP_CONSUME, 31'd16484);

        load_setting(31'd32768, 23'd16384, 1'b1);
        run_phase(80, 1'b0, 30, -1);
        load_setting(31'd49152, 23'd20000, 1'b0);
        run_phase(70, 1'b1, -1, 35);
        load_setting(31'd131072, 23'd16384, 1'b1);
        run_phase(70, 1'b1, 50, -1);
        load_setting(31'd1 << 30, 23'd4194304, 1'b1);
        run_phase(40, 1'b1, -1, -1);
        load_setting(31'd65536, 23'd4194304, 1'b1);
        run_phase(60, 1'b1, -1, 20);
        repeat (2) begin
            load_setting($urandom_range(32768, 262144), $urandom_range(16384, 4194304),
                         $urandom_range(0, 1));
            run_phase(60, 1'b1, -1, -1);
        end

        drain();
        repeat (8)
            @(posedge clk);
        if (board.errors == 0 && board.pending() == 0)
            $display("ring_buffer_flow_control verification clean");
        else
            $display("ring_buffer_flow_control verification failed");
        $finish;
    end

    // Stop a hung run
    initial begin : watchdog
        #2_000_000;
        $display("ring_buffer_flow_control verification failed");
        $finish;
    end

endmodule

>>> sim.f
rtl/rbfc_pkg.sv
rtl/rbfc_if.sv
rtl/rbfc_ctrl.sv
rtl/rbfc_datapath.sv
rtl/ring_buffer_flow_control.sv
tb/tb.sv
